// ----- hw/rtl/scs1_pkg.sv -----
`default_nettype none

package scs1_pkg;

  // Held modifiers and lock toggles
  typedef struct packed {
    logic scroll;
    logic num;
    logic caps;
    logic shift;
    logic ctrl;
    logic alt;
  } scs1_mods_t;

  typedef struct packed {
    logic       reboot_request;
    logic [2:0] led_bits;       // bit0 scroll, bit1 num, bit2 caps
    logic       led_update;
    logic [7:0] char_code;
    logic       char_valid;
  } scs1_result_t;

  localparam int unsigned ResultW = $bits(scs1_result_t);
  localparam int unsigned TdataW  = ((ResultW + 7) / 8) * 8;

  // Make codes (bit 7 stripped)
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_NUM    = 7'h45;
  localparam logic [6:0] SC_SCRL   = 7'h46;
  localparam logic [6:0] SC_DEL    = 7'h53;
  localparam logic [6:0] MAP_LEN   = 7'h59;

  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] CTRL_BIAS = 8'h60;

  // Unshifted map; codes at or above MAP_LEN give 0
  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'h01: c = 8'h1B;
      7'h02: c = 8'h31;
      7'h03: c = 8'h32;
      7'h04: c = 8'h33;
      7'h05: c = 8'h34;
      7'h06: c = 8'h35;
      7'h07: c = 8'h36;
      7'h08: c = 8'h37;
      7'h09: c = 8'h38;
      7'h0A: c = 8'h39;
      7'h0B: c = 8'h30;
      7'h0C: c = 8'h2D;
      7'h0D: c = 8'h3D;
      7'h0E: c = 8'h08;
      7'h0F: c = 8'h09;
      7'h10: c = 8'h71;
      7'h11: c = 8'h77;
      7'h12: c = 8'h65;
      7'h13: c = 8'h72;
      7'h14: c = 8'h74;
      7'h15: c = 8'h79;
      7'h16: c = 8'h75;
      7'h17: c = 8'h69;
      7'h18: c = 8'h6F;
      7'h19: c = 8'h70;
      7'h1A: c = 8'h5B;
      7'h1B: c = 8'h5D;
      7'h1C: c = 8'h0A;
      7'h1E: c = 8'h61;
      7'h1F: c = 8'h73;
      7'h20: c = 8'h64;
      7'h21: c = 8'h66;
      7'h22: c = 8'h67;
      7'h23: c = 8'h68;
      7'h24: c = 8'h6A;
      7'h25: c = 8'h6B;
      7'h26: c = 8'h6C;
      7'h27: c = 8'h3B;
      7'h28: c = 8'h27;
      7'h29: c = 8'h60;
      7'h2B: c = 8'h5C;
      7'h2C: c = 8'h7A;
      7'h2D: c = 8'h78;
      7'h2E: c = 8'h63;
      7'h2F: c = 8'h76;
      7'h30: c = 8'h62;
      7'h31: c = 8'h6E;
      7'h32: c = 8'h6D;
      7'h33: c = 8'h2C;
      7'h34: c = 8'h2E;
      7'h35: c = 8'h2F;
      7'h39: c = 8'h20;
      7'h3B: c = 8'h80;
      7'h3C: c = 8'h81;
      7'h3D: c = 8'h82;
      7'h3E: c = 8'h83;
      7'h3F: c = 8'h84;
      7'h40: c = 8'h85;
      7'h41: c = 8'h86;
      7'h42: c = 8'h87;
      7'h43: c = 8'h88;
      7'h44: c = 8'h89;
      7'h47: c = 8'h8C;
      7'h48: c = 8'h8D;
      7'h49: c = 8'h8E;
      7'h4A: c = 8'h2D;
      7'h4B: c = 8'h8F;
      7'h4C: c = 8'h35;
      7'h4D: c = 8'h90;
      7'h4E: c = 8'h2B;
      7'h4F: c = 8'h91;
      7'h50: c = 8'h92;
      7'h51: c = 8'h93;
      7'h52: c = 8'h94;
      7'h53: c = 8'h95;
      7'h57: c = 8'h8A;
      7'h58: c = 8'h8B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted map: letters upper-cased, digit and punctuation keys swapped, rest as plain
  function automatic logic [7:0] shift_char(input logic [6:0] key);
    logic [7:0] p;
    logic [7:0] c;
    p = plain_char(key);
    case (key)
      7'h02: c = 8'h21;
      7'h03: c = 8'h40;
      7'h04: c = 8'h23;
      7'h05: c = 8'h24;
      7'h06: c = 8'h25;
      7'h07: c = 8'h5E;
      7'h08: c = 8'h26;
      7'h09: c = 8'h2A;
      7'h0A: c = 8'h28;
      7'h0B: c = 8'h29;
      7'h0C: c = 8'h5F;
      7'h0D: c = 8'h2B;
      7'h1A: c = 8'h7B;
      7'h1B: c = 8'h7D;
      7'h27: c = 8'h3A;
      7'h28: c = 8'h22;
      7'h29: c = 8'h7E;
      7'h2B: c = 8'h7C;
      7'h33: c = 8'h3C;
      7'h34: c = 8'h3E;
      7'h35: c = 8'h3F;
      default: begin
        if (p >= CHR_LC_A && p <= CHR_LC_Z) c = p - CASE_GAP;
        else c = p;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scs1_xlate.sv -----
`default_nettype none

// Decode of one scancode against the current modifiers
module scs1_xlate
  import scs1_pkg::*;
(
  input  wire logic [7:0]   scancode,
  input  wire scs1_mods_t   mods,
  output scs1_mods_t        mods_next,
  output scs1_result_t      result
);

  logic [6:0] key;
  logic       brk;
  logic [7:0] plain;
  logic [7:0] code;

  assign key   = scancode[6:0];
  assign brk   = scancode[7];
  assign plain = plain_char(key);

  always_comb begin
    if (mods.ctrl) begin
      if (plain >= CHR_LC_A && plain <= CHR_LC_Z) code = plain - CTRL_BIAS;
      else code = 8'h00;
    end else if (mods.shift || mods.caps) begin
      code = shift_char(key);
    end else if (mods.alt) begin
      code = 8'h00;
    end else begin
      code = plain;
    end
  end

  always_comb begin
    mods_next             = mods;
    result.char_valid     = 1'b0;
    result.char_code      = 8'h00;
    result.led_update     = 1'b0;
    result.reboot_request = 1'b0;
    if (brk) begin
      if (key == SC_ALT) mods_next.alt = 1'b0;
      else if (key == SC_CTRL) mods_next.ctrl = 1'b0;
      else if (key inside {SC_LSHIFT, SC_RSHIFT}) mods_next.shift = 1'b0;
    end else if (key == SC_ALT) begin
      mods_next.alt = 1'b1;
    end else if (key == SC_CTRL) begin
      mods_next.ctrl = 1'b1;
    end else if (key inside {SC_LSHIFT, SC_RSHIFT}) begin
      mods_next.shift = 1'b1;
    end else if (key == SC_SCRL) begin
      mods_next.scroll  = ~mods.scroll;
      result.led_update = 1'b1;
    end else if (key == SC_NUM) begin
      mods_next.num     = ~mods.num;
      result.led_update = 1'b1;
    end else if (key == SC_CAPS) begin
      mods_next.caps    = ~mods.caps;
      result.led_update = 1'b1;
    end else if (mods.ctrl && mods.alt && key == SC_DEL) begin
      result.reboot_request = 1'b1;
    end else if (key < MAP_LEN) begin
      result.char_valid = 1'b1;
      result.char_code  = code;
    end
    // LED word always tracks the lock state after this item
    result.led_bits = {mods_next.caps, mods_next.num, mods_next.scroll};
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scancode_set1_to_ascii.sv -----
`default_nettype none

// PC set-1 scancode translator. Each item on the slave side is one raw
// keyboard byte (bit 7 set for a key release); each byte gives exactly one
// result item on the master side. Alt, Ctrl and Shift are held while made,
// Caps, Num and Scroll Lock toggle on make and raise led_update with the new
// LED word (scroll=1, num=2, caps=4) to follow command 0xED. Ctrl+Alt+Del
// raises reboot_request instead of a character. Without Ctrl or Alt, special
// keys come out as 0x80-0x8B (F1-F12) and 0x8C-0x95 (Home, Up, PgUp, Left,
// Right, End, Down, PgDn, Ins, Del). One item is taken every cycle; a result
// passes from the input register through one table lookup and modifier
// update into the result register. The block stalls only when both
// registers hold items and m_tready is low. Modifiers reset to all clear.
module scancode_set1_to_ascii
  import scs1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] scancode
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [TdataW-1:0] m_tdata    // [0] char_valid, [8:1] char_code,
                                            // [9] led_update, [12:10] led_bits,
                                            // [13] reboot_request, rest zero
);

  logic         in_valid;
  logic [7:0]   in_code;
  logic         out_valid;
  scs1_result_t out_data;
  scs1_mods_t   mods;
  scs1_mods_t   mods_next;
  scs1_result_t result;
  logic         advance;

  // Item moves from input register to result register
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  scs1_xlate u_xlate (
    .scancode  (in_code),
    .mods      (mods),
    .mods_next (mods_next),
    .result    (result)
  );

  // Modifier state commits as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
    end else if (advance) begin
      mods <= mods_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(TdataW - ResultW){1'b0}}, out_data};

endmodule

`default_nettype wire

// ----- hw/rtl/scs1_checker.sv -----
`default_nettype none

module scs1_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  logic       out_fire;
  logic       in_fire;
  logic [2:0] last_led;

  assign out_fire = m_tvalid && m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // LED word seen on the last delivered item (all clear after reset)
  always_ff @(posedge clk) begin
    if (rst) begin
      last_led <= 3'd0;
    end else if (out_fire) begin
      last_led <= m_tdata[12:10];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'h00)
    else $error("char_code set without char_valid");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({m_tdata[0], m_tdata[9], m_tdata[13]}))
    else $error("character, LED update and reboot in one item");

  a_led_steady: assert property (@(posedge clk) disable iff (rst)
    out_fire && !m_tdata[9] |-> m_tdata[12:10] == last_led)
    else $error("LED word changed without led_update");

  a_no_out_from_nothing: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_fire, 2) || $past(m_tvalid))
    else $error("result item without an accepted byte");

endmodule

bind scancode_set1_to_ascii scs1_checker u_scs1_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb
  import scs1_pkg::*;
;

  // Stimulus codes that the package does not name
  localparam logic [7:0] REL_BIT  = 8'h80;  // set on every key release
  localparam logic [7:0] KEY_ESC  = 8'h01;
  localparam logic [7:0] KEY_1    = 8'h02;
  localparam logic [7:0] KEY_A    = 8'h1E;
  localparam logic [7:0] KEY_HOLE = 8'h54;  // inside the map, no character
  localparam logic [7:0] KEY_F12  = 8'h58;  // last mapped code
  localparam logic [7:0] KEY_OFF  = 8'h59;  // first code past the map

  localparam int LONG_HOLD = 150;           // receiver hold-off, cycles
  localparam int TAIL      = 8;             // settle time after the last item

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_EVERY4} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [TdataW-1:0] m_tdata;

  always #5 clk = ~clk;

  scancode_set1_to_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // ---------------------------------------------------------------------
  // Translation predictor: own copy of the modifier state and key maps
  // ---------------------------------------------------------------------
  scs1_mods_t held = '0;

  logic [7:0] plain_map [0:88] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
    8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h8C,
    8'h8D, 8'h8E, 8'h2D, 8'h8F, 8'h35, 8'h90, 8'h2B, 8'h91,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h00, 8'h00, 8'h00, 8'h8A,
    8'h8B
  };

  logic [7:0] shifted_map [0:88] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h20, 8'h00, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84,
    8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h00, 8'h00, 8'h8C,
    8'h8D, 8'h8E, 8'h2D, 8'h8F, 8'h35, 8'h90, 8'h2B, 8'h91,
    8'h92, 8'h93, 8'h94, 8'h95, 8'h00, 8'h00, 8'h00, 8'h8A,
    8'h8B
  };

  // Character for a mapped make code under the current modifiers
  function automatic logic [7:0] key_char(input logic [6:0] key);
    logic [7:0] c;
    c = plain_map[key];
    if (held.ctrl) begin
      // control letters 1-26, anything else 0
      if (c >= CHR_LC_A && c <= CHR_LC_Z) return c - CTRL_BIAS;
      return 8'h00;
    end
    if (held.shift || held.caps) return shifted_map[key];
    if (held.alt) return 8'h00;
    return c;
  endfunction

  // Result for one scancode byte; updates the held modifiers
  function automatic scs1_result_t translate_byte(input logic [7:0] sc);
    scs1_result_t r;
    logic [6:0]   key;
    r   = '0;
    key = sc[6:0];
    if (sc[7]) begin
      // only held modifiers react to a release
      if (key == SC_ALT) held.alt = 1'b0;
      else if (key == SC_CTRL) held.ctrl = 1'b0;
      else if (key == SC_LSHIFT || key == SC_RSHIFT) held.shift = 1'b0;
    end else if (key == SC_ALT) begin
      held.alt = 1'b1;
    end else if (key == SC_CTRL) begin
      held.ctrl = 1'b1;
    end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
      held.shift = 1'b1;
    end else if (key == SC_SCRL) begin
      held.scroll = ~held.scroll;
      r.led_update = 1'b1;
    end else if (key == SC_NUM) begin
      held.num = ~held.num;
      r.led_update = 1'b1;
    end else if (key == SC_CAPS) begin
      held.caps = ~held.caps;
      r.led_update = 1'b1;
    end else if (held.ctrl && held.alt && key == SC_DEL) begin
      r.reboot_request = 1'b1;
    end else if (key < MAP_LEN) begin
      r.char_valid = 1'b1;
      r.char_code  = key_char(key);
    end
    r.led_bits = {held.caps, held.num, held.scroll};
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: prediction on input handshake, check on output handshake
  // ---------------------------------------------------------------------
  scs1_result_t owed_results[$];
  int           faults = 0;

  task automatic log_fault(input string what, input scs1_result_t want,
                           input scs1_result_t got, input logic [TdataW-1:0] raw);
    faults++;
    if (faults <= 10)
      $display({"%0t %s: want v=%0b c=%02h upd=%0b led=%03b rb=%0b",
                " | got v=%0b c=%02h upd=%0b led=%03b rb=%0b (tdata %04h)"},
               $time, what, want.char_valid, want.char_code, want.led_update,
               want.led_bits, want.reboot_request, got.char_valid, got.char_code,
               got.led_update, got.led_bits, got.reboot_request, raw);
  endtask

  always @(posedge clk) begin
    scs1_result_t got;
    scs1_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = scs1_result_t'(m_tdata[ResultW-1:0]);
        if (owed_results.size() == 0) begin
          log_fault("result with nothing owed", '0, got, m_tdata);
        end else begin
          want = owed_results.pop_front();
          if (got.char_valid != want.char_valid || got.char_code != want.char_code ||
              got.led_update != want.led_update || got.led_bits != want.led_bits ||
              got.reboot_request != want.reboot_request ||
              m_tdata[TdataW-1:ResultW] != '0)
            log_fault("field mismatch", want, got, m_tdata);
        end
      end
      if (s_tvalid && s_tready) owed_results.push_back(translate_byte(s_tdata));
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: switches between free-running, coin-toss and 1-in-4 ready;
  // a long hold-off is requested by bumping hold_asks
  // ---------------------------------------------------------------------
  int       hold_asks = 0;
  int       hold_seen = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_phase  = 0;
  rx_mode_t rx_mode   = RX_FREE;

  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_FREE:  m_tready <= 1'b1;
        RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
        default:  m_tready <= (rx_phase % 4 == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] sc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sc;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Map ends, holes, bytes past the map, a release with nothing held
  task automatic test_plain_keys();
    send_byte(8'h00);
    send_byte(KEY_ESC);
    send_byte(KEY_F12);
    send_byte(KEY_OFF);
    send_byte(KEY_HOLE);
    send_byte(8'hFF);
    send_byte({1'b0, SC_DEL});
    wait_drained();
  endtask

  // Shift and Caps pick the shifted map; together they do not invert case
  task automatic test_shift_and_locks();
    send_byte({1'b0, SC_LSHIFT});
    send_byte(KEY_A);
    send_byte(REL_BIT | {1'b0, SC_LSHIFT});
    send_byte({1'b0, SC_CAPS});
    send_byte(KEY_A);
    send_byte({1'b0, SC_RSHIFT});
    send_byte(KEY_A);
    send_byte(REL_BIT | {1'b0, SC_RSHIFT});
    send_byte({1'b0, SC_CAPS});
    send_byte({1'b0, SC_NUM});
    send_byte({1'b0, SC_SCRL});
    wait_drained();
  endtask

  // Ctrl letters, Ctrl non-letter, three-finger salute, Alt alone
  task automatic test_ctrl_alt();
    send_byte({1'b0, SC_CTRL});
    send_byte(KEY_A);
    send_byte(KEY_1);
    send_byte({1'b0, SC_ALT});
    send_byte({1'b0, SC_DEL});
    send_byte(REL_BIT | {1'b0, SC_CTRL});
    send_byte(KEY_A);
    send_byte(REL_BIT | {1'b0, SC_ALT});
    wait_drained();
  endtask

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 3))
      0:       return {1'b0, SC_CTRL};
      1:       return {1'b0, SC_LSHIFT};
      2:       return {1'b0, SC_RSHIFT};
      default: return {1'b0, SC_ALT};
    endcase
  endfunction

  // Mostly typing: modifier makes and breaks around mapped keys, plus
  // locks, Del, stray releases and arbitrary bytes
  function automatic logic [7:0] pick_scancode();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return pick_modifier();
    if (roll < 30) return REL_BIT | pick_modifier();
    if (roll < 35) begin
      case ($urandom_range(0, 2))
        0:       return {1'b0, SC_CAPS};
        1:       return {1'b0, SC_NUM};
        default: return {1'b0, SC_SCRL};
      endcase
    end
    if (roll < 40) return {1'b0, SC_DEL};
    if (roll < 75) return 8'($urandom_range(1, MAP_LEN - 1));
    if (roll < 85) return REL_BIT | 8'($urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_typing(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(pick_scancode());
      if (i % 300 == 299) wait_drained();
    end
    wait_drained();
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_output_hold();
    hold_asks++;
    for (int i = 0; i < 40; i++) send_byte(pick_scancode());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_keys();
    test_shift_and_locks();
    test_ctrl_alt();
    test_output_hold();
    test_random_typing(700);
    test_output_hold();
    test_random_typing(640);

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (faults == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
